/* src/mvte_pkg.sv */
// Package for the MAC-based VLAN translation engine.
// Holds the request and status codes, table entry and result types, and the
// command and status structs between controller and datapath. No dependencies.
package mvte_pkg;

    localparam int CLIENT_ENTRIES_DEF  = 64;
    localparam int ROUTER_ENTRIES_DEF  = 16;
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam logic [15:0] TPID_8021Q = 16'h8100;
    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] REQ_ADD_CLIENT   = 2'd0;
    localparam logic [1:0] REQ_ADD_ROUTER   = 2'd1;
    localparam logic [1:0] REQ_CLIENT_FRAME = 2'd2;
    localparam logic [1:0] REQ_ROUTER_FRAME = 2'd3;

    localparam logic [3:0] ST_TO_ROUTER   = 4'd0;
    localparam logic [3:0] ST_TO_CLIENT   = 4'd1;
    localparam logic [3:0] ST_UNK_SRC     = 4'd2;
    localparam logic [3:0] ST_BAD_TAG     = 4'd3;
    localparam logic [3:0] ST_UNK_DEST    = 4'd4;
    localparam logic [3:0] ST_MISMATCH    = 4'd5;
    localparam logic [3:0] ST_NO_RECEIVER = 4'd6;
    localparam logic [3:0] ST_ADDED       = 4'd7;
    localparam logic [3:0] ST_EXISTS      = 4'd8;
    localparam logic [3:0] ST_FULL        = 4'd9;

    localparam logic [0:0] CFG_FWD_MCAST  = 1'd0;
    localparam logic [0:0] CFG_OUTER_TPID = 1'd1;

    // How a result beat is built.
    localparam logic [1:0] EK_PLAIN   = 2'd0;
    localparam logic [1:0] EK_ROUTER  = 2'd1;
    localparam logic [1:0] EK_CLIENT  = 2'd2;
    localparam logic [1:0] EK_PENDING = 2'd3;

    // Where a plain result takes its client index from.
    localparam logic [1:0] IDX_ZERO  = 2'd0;
    localparam logic [1:0] IDX_SCAN  = 2'd1;
    localparam logic [1:0] IDX_COUNT = 2'd2;

    typedef struct packed {
        logic [47:0] mac;
        logic [11:0] rvlan;
        logic [11:0] ovid;
        logic [11:0] ivid;
    } client_ent_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [11:0] vlan;
    } router_ent_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] outer_tpid;
        logic [15:0] outer_tci;
        logic        two_tags;
        logic [15:0] inner_tpid;
        logic [15:0] inner_tci;
        logic [11:0] len;
        logic [5:0]  client_index;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       scan_clr;
        logic       scan_inc;
        logic       cl_add;
        logic       cl_set_rvlan;
        logic       cl_learn;
        logic       rt_add;
        logic       flood_clr;
        logic       flood_take;
        logic       emit;
        logic [1:0] emit_kind;
        logic [1:0] idx_sel;
        logic [3:0] emit_status;
        logic       emit_last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       cl_end;
        logic       rt_end;
        logic       cl_hit;
        logic       rt_hit;
        logic       cl_full;
        logic       rt_full;
        logic       tag_ok_client;
        logic       tag_ok_router;
        logic       unicast;
        logic       rvlan_eq;
        logic       flood_new;
        logic       pend_valid;
    } stat_t;

endpackage

/* src/mvte_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mvte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/mvte_ctrl.sv */
// Controller state machine for the VLAN translation engine.
// Sequences table scans, updates and result beats; uses mvte_pkg.
module mvte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mvte_pkg::stat_t st,
    output mvte_pkg::cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_CRD  = 4'd2;
    localparam logic [3:0] S_CCMP = 4'd3;
    localparam logic [3:0] S_RRD  = 4'd4;
    localparam logic [3:0] S_RCMP = 4'd5;
    localparam logic [3:0] S_FRD  = 4'd6;
    localparam logic [3:0] S_FCMP = 4'd7;
    localparam logic [3:0] S_FEND = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load     = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP:
            begin
                case (st.req)
                    mvte_pkg::REQ_ADD_ROUTER:
                    begin
                        state_next = S_RRD;
                    end
                    mvte_pkg::REQ_ROUTER_FRAME:
                    begin
                        if (!st.tag_ok_router)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = mvte_pkg::ST_BAD_TAG;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_RRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_CRD;
                    end
                endcase
            end
            S_CRD:
            begin
                if (st.cl_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    case (st.req)
                        mvte_pkg::REQ_ADD_CLIENT:
                        begin
                            if (st.cl_full)
                            begin
                                cmd.emit_status = mvte_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.cl_add      = 1'b1;
                                cmd.emit_status = mvte_pkg::ST_ADDED;
                                cmd.idx_sel     = mvte_pkg::IDX_COUNT;
                            end
                        end
                        mvte_pkg::REQ_CLIENT_FRAME:
                        begin
                            cmd.emit_status = mvte_pkg::ST_UNK_SRC;
                        end
                        default:
                        begin
                            cmd.emit_status = mvte_pkg::ST_UNK_DEST;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_CCMP;
                end
            end
            S_CCMP:
            begin
                if (st.cl_hit)
                begin
                    cmd.emit    = 1'b1;
                    cmd.idx_sel = mvte_pkg::IDX_SCAN;
                    state_next  = S_IDLE;
                    case (st.req)
                        mvte_pkg::REQ_ADD_CLIENT:
                        begin
                            cmd.cl_set_rvlan = 1'b1;
                            cmd.emit_status  = mvte_pkg::ST_EXISTS;
                        end
                        mvte_pkg::REQ_CLIENT_FRAME:
                        begin
                            if (!st.tag_ok_client)
                            begin
                                cmd.emit_status = mvte_pkg::ST_BAD_TAG;
                            end
                            else
                            begin
                                cmd.cl_learn  = 1'b1;
                                cmd.emit_kind = mvte_pkg::EK_ROUTER;
                            end
                        end
                        default:
                        begin
                            if (!st.rvlan_eq)
                            begin
                                cmd.emit_status = mvte_pkg::ST_MISMATCH;
                            end
                            else
                            begin
                                cmd.emit_kind = mvte_pkg::EK_CLIENT;
                            end
                        end
                    endcase
                end
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_CRD;
                end
            end
            S_RRD:
            begin
                if (st.rt_end)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    if (st.req == mvte_pkg::REQ_ADD_ROUTER)
                    begin
                        if (st.rt_full)
                        begin
                            cmd.emit_status = mvte_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.rt_add      = 1'b1;
                            cmd.emit_status = mvte_pkg::ST_ADDED;
                        end
                    end
                    else
                    begin
                        cmd.emit_status = mvte_pkg::ST_UNK_SRC;
                    end
                end
                else
                begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                if (!st.rt_hit)
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_RRD;
                end
                else if (st.req == mvte_pkg::REQ_ADD_ROUTER)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = mvte_pkg::ST_EXISTS;
                    state_next      = S_IDLE;
                end
                else if (st.unicast)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_CRD;
                end
                else
                begin
                    cmd.scan_clr  = 1'b1;
                    cmd.flood_clr = 1'b1;
                    state_next    = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = st.cl_end ? S_FEND : S_FCMP;
            end
            S_FCMP:
            begin
                // A copy is held back one step so that the final one can carry last.
                if (st.flood_new)
                begin
                    cmd.flood_take = 1'b1;
                    if (st.pend_valid)
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = mvte_pkg::EK_PENDING;
                    end
                end
                cmd.scan_inc = 1'b1;
                state_next   = S_FRD;
            end
            S_FEND:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
                if (st.pend_valid)
                begin
                    cmd.emit_kind = mvte_pkg::EK_PENDING;
                    cmd.emit_last = 1'b1;
                end
                else
                begin
                    cmd.emit_status = mvte_pkg::ST_NO_RECEIVER;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/mvte_datapath.sv */
// Datapath of the VLAN translation engine: request latch, configuration,
// client and router tables, flood bookkeeping and the result register.
// Uses mvte_pkg and mvte_ram.
module mvte_datapath #(
    parameter int CLIENT_ENTRIES  = mvte_pkg::CLIENT_ENTRIES_DEF,
    parameter int ROUTER_ENTRIES  = mvte_pkg::ROUTER_ENTRIES_DEF,
    parameter int MAX_FRAME_BYTES = mvte_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [1:0]        req_type,
    input  logic [47:0]       dst_mac,
    input  logic [47:0]       src_mac,
    input  logic [15:0]       first_tpid,
    input  logic [15:0]       first_tci,
    input  logic [15:0]       second_tpid,
    input  logic [15:0]       second_tci,
    input  logic [11:0]       frame_len,
    input  logic [47:0]       entry_mac,
    input  logic [11:0]       entry_vlan,
    input  mvte_pkg::cmd_t    cmd,
    output mvte_pkg::stat_t   st,
    output logic              res_valid,
    output mvte_pkg::result_t res
);

    localparam int CAW = $clog2(CLIENT_ENTRIES);
    localparam int RAW = $clog2(ROUTER_ENTRIES);
    localparam int CIW = $clog2(CLIENT_ENTRIES + 1);
    localparam int RIW = $clog2(ROUTER_ENTRIES + 1);
    localparam int SW  = (CIW > RIW) ? CIW : RIW;
    localparam int LEN_CLAMP = MAX_FRAME_BYTES + 4;
    localparam int CEW = $bits(mvte_pkg::client_ent_t);
    localparam int REW = $bits(mvte_pkg::router_ent_t);

    logic        fwd_mcast_reg;
    logic [15:0] outer_tpid_reg;

    logic [1:0]  req_reg;
    logic [47:0] dst_reg;
    logic [47:0] src_reg;
    logic [15:0] t1p_reg;
    logic [15:0] t1c_reg;
    logic [15:0] t2p_reg;
    logic [15:0] t2c_reg;
    logic [11:0] len_reg;
    logic [47:0] emac_reg;
    logic [11:0] evlan_reg;

    logic [SW-1:0]  idx_reg;
    logic [CIW-1:0] cl_count_reg;
    logic [RIW-1:0] rt_count_reg;

    logic [11:0]         serv_vid_reg [CLIENT_ENTRIES];
    logic [CLIENT_ENTRIES-1:0] serv_valid_reg;
    logic [CIW-1:0]      serv_cnt_reg;
    logic                pend_valid_reg;
    mvte_pkg::result_t   pend_reg;

    logic              res_valid_reg;
    mvte_pkg::result_t res_reg;

    mvte_pkg::client_ent_t cl_rd;
    mvte_pkg::client_ent_t cl_wdata;
    logic [CEW-1:0]        cl_rdata;
    logic                  cl_we;
    logic [CAW-1:0]        cl_waddr;
    mvte_pkg::router_ent_t rt_rd;
    logic [REW-1:0]        rt_rdata;

    logic [47:0]       cl_key;
    logic [47:0]       rt_key_mac;
    logic [11:0]       rt_key_vlan;
    logic [11:0]       rvlan;
    logic              two_in;
    logic              seen;
    logic [CLIENT_ENTRIES-1:0] seen_vec;
    logic [5:0]        scan_index;
    mvte_pkg::result_t copy;
    mvte_pkg::result_t res_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_mcast_reg  <= 1'b0;
            outer_tpid_reg <= mvte_pkg::TPID_8021Q;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mvte_pkg::CFG_FWD_MCAST)
            begin
                fwd_mcast_reg <= cfg_data[0];
            end
            else
            begin
                outer_tpid_reg <= cfg_data;
            end
        end
    end

    // Request latch; the length is clamped on the way in.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            dst_reg   <= dst_mac;
            src_reg   <= src_mac;
            t1p_reg   <= first_tpid;
            t1c_reg   <= first_tci;
            t2p_reg   <= second_tpid;
            t2c_reg   <= second_tci;
            emac_reg  <= entry_mac;
            evlan_reg <= entry_vlan;
            if (int'(frame_len) > LEN_CLAMP)
            begin
                len_reg <= 12'(LEN_CLAMP);
            end
            else
            begin
                len_reg <= frame_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            cl_count_reg <= '0;
            rt_count_reg <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.cl_add)
            begin
                cl_count_reg <= cl_count_reg + 1'b1;
            end
            if (cmd.rt_add)
            begin
                rt_count_reg <= rt_count_reg + 1'b1;
            end
        end
    end

    assign cl_rd = mvte_pkg::client_ent_t'(cl_rdata);
    assign rt_rd = mvte_pkg::router_ent_t'(rt_rdata);

    assign cl_we    = cmd.cl_add | cmd.cl_set_rvlan | cmd.cl_learn;
    assign cl_waddr = cmd.cl_add ? cl_count_reg[CAW-1:0] : idx_reg[CAW-1:0];

    always_comb
    begin
        cl_wdata = cl_rd;
        if (cmd.cl_add)
        begin
            cl_wdata.mac   = emac_reg;
            cl_wdata.rvlan = evlan_reg;
            cl_wdata.ovid  = '0;
            cl_wdata.ivid  = '0;
        end
        else if (cmd.cl_set_rvlan)
        begin
            cl_wdata.rvlan = evlan_reg;
        end
        else
        begin
            cl_wdata.ovid = t1c_reg[11:0];
            cl_wdata.ivid = two_in ? t2c_reg[11:0] : 12'd0;
        end
    end

    mvte_ram #(
        .WIDTH (CEW),
        .DEPTH (CLIENT_ENTRIES)
    ) u_client_ram (
        .clk   (clk),
        .we    (cl_we),
        .waddr (cl_waddr),
        .wdata (cl_wdata),
        .raddr (idx_reg[CAW-1:0]),
        .rdata (cl_rdata)
    );

    mvte_ram #(
        .WIDTH (REW),
        .DEPTH (ROUTER_ENTRIES)
    ) u_router_ram (
        .clk   (clk),
        .we    (cmd.rt_add),
        .waddr (rt_count_reg[RAW-1:0]),
        .wdata ({emac_reg, evlan_reg}),
        .raddr (idx_reg[RAW-1:0]),
        .rdata (rt_rdata)
    );

    assign rvlan  = t1c_reg[11:0];
    assign two_in = (t2p_reg == mvte_pkg::TPID_8021Q);

    always_comb
    begin
        case (req_reg)
            mvte_pkg::REQ_ADD_CLIENT:   cl_key = emac_reg;
            mvte_pkg::REQ_CLIENT_FRAME: cl_key = src_reg;
            default:                    cl_key = dst_reg;
        endcase
    end

    assign rt_key_mac  = (req_reg == mvte_pkg::REQ_ADD_ROUTER) ? emac_reg : src_reg;
    assign rt_key_vlan = (req_reg == mvte_pkg::REQ_ADD_ROUTER) ? evlan_reg : rvlan;

    // Outer VIDs already served in this flood.
    always_comb
    begin
        for (int i = 0; i < CLIENT_ENTRIES; i++)
        begin
            seen_vec[i] = serv_valid_reg[i] && (serv_vid_reg[i] == cl_rd.ovid);
        end
    end
    assign seen = |seen_vec;

    assign st.req           = req_reg;
    assign st.cl_end        = (idx_reg >= SW'(cl_count_reg));
    assign st.rt_end        = (idx_reg >= SW'(rt_count_reg));
    assign st.cl_hit        = (cl_rd.mac == cl_key);
    assign st.rt_hit        = (rt_rd.mac == rt_key_mac) && (rt_rd.vlan == rt_key_vlan);
    assign st.cl_full       = (cl_count_reg >= CIW'(CLIENT_ENTRIES));
    assign st.rt_full       = (rt_count_reg >= RIW'(ROUTER_ENTRIES));
    assign st.tag_ok_client = (t1p_reg == outer_tpid_reg) || (t1p_reg == mvte_pkg::TPID_8021Q);
    assign st.tag_ok_router = (t1p_reg == mvte_pkg::TPID_8021Q);
    assign st.unicast       = !(fwd_mcast_reg && dst_reg[40]) && (dst_reg != mvte_pkg::MAC_BCAST);
    assign st.rvlan_eq      = (cl_rd.rvlan == rvlan);
    assign st.flood_new     = st.rvlan_eq && !seen;
    assign st.pend_valid    = pend_valid_reg;

    assign scan_index = 6'(idx_reg[CAW-1:0]);

    // Copy of the frame towards the client currently read.
    always_comb
    begin
        copy              = '0;
        copy.status       = mvte_pkg::ST_TO_CLIENT;
        copy.outer_tci    = {4'd0, cl_rd.ovid};
        copy.client_index = scan_index;
        if (cl_rd.ivid == 12'd0)
        begin
            copy.outer_tpid = mvte_pkg::TPID_8021Q;
            copy.len        = len_reg;
        end
        else
        begin
            copy.outer_tpid = outer_tpid_reg;
            copy.two_tags   = 1'b1;
            copy.inner_tpid = mvte_pkg::TPID_8021Q;
            copy.inner_tci  = {4'd0, cl_rd.ivid};
            copy.len        = len_reg + 12'd4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            serv_valid_reg <= '0;
            serv_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.flood_clr)
        begin
            serv_valid_reg <= '0;
            serv_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.flood_take)
        begin
            serv_valid_reg[serv_cnt_reg[CAW-1:0]] <= 1'b1;
            serv_cnt_reg   <= serv_cnt_reg + 1'b1;
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.flood_take)
        begin
            serv_vid_reg[serv_cnt_reg[CAW-1:0]] <= cl_rd.ovid;
            pend_reg <= copy;
        end
    end

    always_comb
    begin
        res_next = '0;
        case (cmd.emit_kind)
            mvte_pkg::EK_ROUTER:
            begin
                res_next.status       = mvte_pkg::ST_TO_ROUTER;
                res_next.outer_tpid   = t1p_reg;
                res_next.outer_tci    = {4'd0, cl_rd.rvlan};
                res_next.two_tags     = two_in;
                res_next.inner_tpid   = two_in ? t2p_reg : 16'd0;
                res_next.inner_tci    = two_in ? t2c_reg : 16'd0;
                res_next.len          = len_reg;
                res_next.client_index = scan_index;
                res_next.last         = 1'b1;
            end
            mvte_pkg::EK_CLIENT:
            begin
                res_next      = copy;
                res_next.last = 1'b1;
            end
            mvte_pkg::EK_PENDING:
            begin
                res_next      = pend_reg;
                res_next.last = cmd.emit_last;
            end
            default:
            begin
                res_next.status = cmd.emit_status;
                res_next.last   = 1'b1;
                case (cmd.idx_sel)
                    mvte_pkg::IDX_SCAN:  res_next.client_index = scan_index;
                    mvte_pkg::IDX_COUNT: res_next.client_index = 6'(cl_count_reg[CAW-1:0]);
                    default:             res_next.client_index = 6'd0;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* src/mac_vlan_translation_engine_unit.sv */
// Top level of the MAC-based VLAN translation engine: controller plus datapath.
// Each lookup reads the table entries one by one (registered RAM read, then compare);
// a client frame gives its beat once the client scan reaches that client's entry.
// A unicast router frame adds the router scan; a flood walks every client.
// One item at a time: busy drops in the cycle of the final beat, when the next may start.
// Reset clears the counts and returns the configuration to its defaults at once; the receiver cannot stall.
module mac_vlan_translation_engine_unit #(
    parameter int CLIENT_ENTRIES  = mvte_pkg::CLIENT_ENTRIES_DEF,
    parameter int ROUTER_ENTRIES  = mvte_pkg::ROUTER_ENTRIES_DEF,
    parameter int MAX_FRAME_BYTES = mvte_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [47:0] dst_mac,
    input  logic [47:0] src_mac,
    input  logic [15:0] first_tpid,
    input  logic [15:0] first_tci,
    input  logic [15:0] second_tpid,
    input  logic [15:0] second_tci,
    input  logic [11:0] frame_len,
    input  logic [47:0] entry_mac,
    input  logic [11:0] entry_vlan,
    output logic        result_valid,
    output logic [3:0]  status,
    output logic [15:0] out_outer_tpid,
    output logic [15:0] out_outer_tci,
    output logic        out_two_tags,
    output logic [15:0] out_inner_tpid,
    output logic [15:0] out_inner_tci,
    output logic [11:0] out_len,
    output logic [5:0]  client_index,
    output logic        last
);

    mvte_pkg::cmd_t    cmd;
    mvte_pkg::stat_t   st;
    mvte_pkg::result_t res;

    mvte_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .st    (st),
        .cmd   (cmd)
    );

    mvte_datapath #(
        .CLIENT_ENTRIES  (CLIENT_ENTRIES),
        .ROUTER_ENTRIES  (ROUTER_ENTRIES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .dst_mac     (dst_mac),
        .src_mac     (src_mac),
        .first_tpid  (first_tpid),
        .first_tci   (first_tci),
        .second_tpid (second_tpid),
        .second_tci  (second_tci),
        .frame_len   (frame_len),
        .entry_mac   (entry_mac),
        .entry_vlan  (entry_vlan),
        .cmd         (cmd),
        .st          (st),
        .res_valid   (result_valid),
        .res         (res)
    );

    assign status         = res.status;
    assign out_outer_tpid = res.outer_tpid;
    assign out_outer_tci  = res.outer_tci;
    assign out_two_tags   = res.two_tags;
    assign out_inner_tpid = res.inner_tpid;
    assign out_inner_tci  = res.inner_tci;
    assign out_len        = res.len;
    assign client_index   = res.client_index;
    assign last           = res.last;

    // A beat only follows a cycle in which an item was being worked on.
    a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result beat without an item in progress");

    // Only copies towards clients can be anything but the final beat.
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != mvte_pkg::ST_TO_CLIENT) |-> last)
        else $error("non-flood result without last");

    // The final beat of an item leaves the engine idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> !busy)
        else $error("engine still busy after final beat");

    // An accepted item keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but engine not busy");

endmodule
